/* rtl/core/blp_pkg.sv */
// ----------------------------------------------------------------------------
// blp_pkg
// Shared types and defaults for the Bresenham line point generator.
// ----------------------------------------------------------------------------
package blp_pkg;

    localparam int DEFAULT_COORD_BITS = 6;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } blp_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture endpoints, set up first pixel
        logic step;   // advance to next pixel
    } blp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;   // current pixel has the far endpoint's x
    } blp_status_t;

endpackage

/* rtl/core/blp_ctrl.sv */
// ----------------------------------------------------------------------------
// blp_ctrl
// Sequencer: takes one input word, then walks the line one pixel per
// output handshake.
// ----------------------------------------------------------------------------
module blp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  blp_pkg::blp_status_t status,
    output blp_pkg::blp_cmd_t    cmd
);
    import blp_pkg::*;

    blp_state_t state_reg;
    blp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_ready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd.load  = 1'b0;
        cmd.step  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                out_valid = 1'b1;
                cmd.step  = out_ready && !status.last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/blp_datapath.sv */
// ----------------------------------------------------------------------------
// blp_datapath
// Endpoint setup, current pixel registers and the decision term update.
// ----------------------------------------------------------------------------
module blp_datapath #(
    parameter int COORD_BITS = blp_pkg::DEFAULT_COORD_BITS
) (
    input  logic                   clk,
    input  logic [COORD_BITS-1:0]  x_a,
    input  logic [COORD_BITS-1:0]  y_a,
    input  logic [COORD_BITS-1:0]  x_b,
    input  logic [COORD_BITS-1:0]  y_b,
    input  blp_pkg::blp_cmd_t      cmd,
    output blp_pkg::blp_status_t   status,
    output logic [COORD_BITS-1:0]  pixel_x,
    output logic [COORD_BITS:0]    pixel_y
);
    import blp_pkg::*;

    localparam int DW = COORD_BITS + 3;   // decision term, signed
    localparam int TW = COORD_BITS + 2;   // 2*dy, unsigned

    localparam logic signed [DW-1:0] DEC_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DEC_MIN = {1'b1, {(DW-1){1'b0}}};

    logic [COORD_BITS-1:0]  cur_x_reg,  cur_x_next;
    logic [COORD_BITS:0]    cur_y_reg,  cur_y_next;
    logic [COORD_BITS-1:0]  end_x_reg,  end_x_next;
    logic signed [DW-1:0]   dec_reg,    dec_next;
    logic [TW-1:0]          tdy_reg,    tdy_next;
    logic signed [DW-1:0]   tdydx_reg,  tdydx_next;

    logic [COORD_BITS-1:0]  dx;
    logic [COORD_BITS-1:0]  dy;
    logic signed [DW:0]     addend;
    logic signed [DW:0]     sum;
    logic signed [DW-1:0]   dec_sat;

    assign dx = (x_a > x_b) ? (x_a - x_b) : (x_b - x_a);
    assign dy = (y_a > y_b) ? (y_a - y_b) : (y_b - y_a);

    // decision update with saturation at the term's signed limits
    assign addend = dec_reg[DW-1] ? $signed({2'b00, tdy_reg})
                                  : {tdydx_reg[DW-1], tdydx_reg};
    assign sum = {dec_reg[DW-1], dec_reg} + addend;

    always_comb
    begin
        if (sum[DW] != sum[DW-1])
        begin
            dec_sat = sum[DW] ? DEC_MIN : DEC_MAX;
        end
        else
        begin
            dec_sat = sum[DW-1:0];
        end
    end

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        end_x_next = end_x_reg;
        dec_next   = dec_reg;
        tdy_next   = tdy_reg;
        tdydx_next = tdydx_reg;
        if (cmd.load)
        begin
            tdy_next   = {1'b0, dy, 1'b0};
            tdydx_next = $signed({2'b00, dy, 1'b0}) - $signed({2'b00, dx, 1'b0});
            dec_next   = $signed({2'b00, dy, 1'b0}) - $signed({3'b000, dx});
            if (x_a > x_b)
            begin
                cur_x_next = x_b;
                cur_y_next = {1'b0, y_b};
                end_x_next = x_a;
            end
            else
            begin
                cur_x_next = x_a;
                cur_y_next = {1'b0, y_a};
                end_x_next = x_b;
            end
        end
        else if (cmd.step)
        begin
            cur_x_next = cur_x_reg + 1'b1;
            if (!dec_reg[DW-1])
            begin
                cur_y_next = cur_y_reg + 1'b1;
            end
            dec_next = dec_sat;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        end_x_reg <= end_x_next;
        dec_reg   <= dec_next;
        tdy_reg   <= tdy_next;
        tdydx_reg <= tdydx_next;
    end

    assign status.last = (cur_x_reg == end_x_reg);
    assign pixel_x     = cur_x_reg;
    assign pixel_y     = cur_y_reg;

endmodule

/* rtl/core/bresenham_line_points.sv */
// First pixel: presented in the cycle after the input word is taken.
// Line length: a line gives dx+1 pixels; a new input word is taken only once
//   the final pixel of the previous line has been delivered.
// Reset: rst_n, asynchronous, active low, returns the sequencer to idle with
//   no output pending; pixel and decision registers are not reset.
// ----------------------------------------------------------------------------
// bresenham_line_points
// Line rasterizer using the first-octant Bresenham rule. Each input word
// holds two endpoints; the block walks x from the endpoint with the
// smaller x to the x of the other, one output word per x step, and flags the
// final pixel with last_pixel.
// ----------------------------------------------------------------------------
module bresenham_line_points #(
    parameter int COORD_BITS = blp_pkg::DEFAULT_COORD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] x_a,
    input  logic [COORD_BITS-1:0] y_a,
    input  logic [COORD_BITS-1:0] x_b,
    input  logic [COORD_BITS-1:0] y_b,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS:0]   pixel_y,
    output logic                  last_pixel
);
    import blp_pkg::*;

    blp_cmd_t    cmd;
    blp_status_t status;

    // Sequencer: idle until a word arrives, then one pixel per output
    // handshake until the far endpoint has been delivered.
    blp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: the current pixel registers double as the output register,
    // so a stalled pixel simply holds until it is taken.
    blp_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk     (clk),
        .x_a     (x_a),
        .y_a     (y_a),
        .x_b     (x_b),
        .y_b     (y_b),
        .cmd     (cmd),
        .status  (status),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y)
    );

    assign last_pixel = status.last;

`ifndef SYNTHESIS
    // never take a new line while pixels are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while line in progress");

    // delivering the final pixel returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_pixel) |=> (in_ready && !out_valid))
        else $error("block not idle after final pixel");

    // a delivered non-final pixel is followed by the next x
    a_x_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_pixel) |=>
            (out_valid && pixel_x == $past(pixel_x) + 1'b1))
        else $error("x did not advance by one");

    // y rises by at most one per step
    a_y_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_pixel) |=>
            (pixel_y == $past(pixel_y) || pixel_y == $past(pixel_y) + 1'b1))
        else $error("y moved by more than one");
`endif

endmodule

/* tb/line_pixel_checker.sv */
// ----------------------------------------------------------------------------
// line_pixel_checker
// Watches both channels of the line point generator. It traces every line
// taken in, queues the pixels that line should produce, and compares each
// pixel word sent out against the oldest queued one.
// ----------------------------------------------------------------------------
module line_pixel_checker #(
    parameter int COORD_BITS = blp_pkg::DEFAULT_COORD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [COORD_BITS-1:0] x_a,
    input  logic [COORD_BITS-1:0] y_a,
    input  logic [COORD_BITS-1:0] x_b,
    input  logic [COORD_BITS-1:0] y_b,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS:0]   pixel_y,
    input  logic                  last_pixel,
    output int                    mismatches,
    output int                    pixels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // decision term is COORD_BITS+3 bits wide, signed, saturating
    localparam int DECISION_MAX = (1 << (COORD_BITS + 2)) - 1;
    localparam int DECISION_MIN = -(1 << (COORD_BITS + 2));
    localparam int MAX_PIXELS   = 1 << COORD_BITS;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS:0]   py;
        logic                  last;
    } pixel_t;

    pixel_t expected_pixels[$];
    int     bad_count     = 0;
    int     pending_count = 0;

    assign mismatches     = bad_count;
    assign pixels_pending = pending_count;

    function automatic int clamp_decision(input int v);
        if (v > DECISION_MAX)
            return DECISION_MAX;
        if (v < DECISION_MIN)
            return DECISION_MIN;
        return v;
    endfunction

    // Walk one line from the endpoint with the smaller x, queueing each pixel.
    task automatic trace_line(input logic [COORD_BITS-1:0] xa, ya, xb, yb);
        int                    dx;
        int                    dy;
        int                    decision;
        int                    step_dy;
        int                    step_diag;
        int                    count;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS:0]   y;
        pixel_t                p;
        dx        = (xa > xb) ? int'(xa) - int'(xb) : int'(xb) - int'(xa);
        dy        = (ya > yb) ? int'(ya) - int'(yb) : int'(yb) - int'(ya);
        decision  = clamp_decision(2 * dy - dx);
        step_dy   = 2 * dy;
        step_diag = 2 * (dy - dx);
        count     = 0;
        if (xa > xb)
        begin
            x     = xb;
            y     = {1'b0, yb};
            x_end = xa;
        end
        else
        begin
            x     = xa;
            y     = {1'b0, ya};
            x_end = xb;
        end
        while (1)
        begin
            p.px   = x;
            p.py   = y;
            p.last = (x >= x_end);
            expected_pixels.push_back(p);
            count++;
            if (p.last || count >= MAX_PIXELS)
                break;
            x = x + 1'b1;
            if (decision < 0)
                decision = clamp_decision(decision + step_dy);
            else
            begin
                y        = y + 1'b1;
                decision = clamp_decision(decision + step_diag);
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        if (bad_count < REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
        bad_count++;
    endtask

    always @(posedge clk)
    begin : monitor
        pixel_t seen;
        pixel_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen.px   = pixel_x;
                seen.py   = pixel_y;
                seen.last = last_pixel;
                if (expected_pixels.size() == 0)
                    note_mismatch($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                            seen.px, seen.py, seen.last));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (seen.px !== want.px || seen.py !== want.py ||
                        seen.last !== want.last)
                        note_mismatch($sformatf(
                            "pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                            want.px, want.py, want.last, seen.px, seen.py, seen.last));
                end
            end
            if (in_valid && in_ready)
                trace_line(x_a, y_a, x_b, y_b);
        end
        pending_count <= expected_pixels.size();
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives endpoint words into the line point generator: a directed set of
// edge cases, then constrained-by-hand random lines, with random gaps on the
// input side and random back-pressure on the output side. The checker beside
// the block predicts every pixel; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB             = blp_pkg::DEFAULT_COORD_BITS;
    localparam int COORD_MAX      = (1 << CB) - 1;
    localparam int RANDOM_LINES   = 250;
    localparam int IDLE_PERCENT   = 35;
    // random lines in this window run with no gaps and no back-pressure
    localparam int CALM_FIRST     = 120;
    localparam int CALM_LAST      = 180;
    localparam int WATCHDOG_LIMIT = 2000;
    // first pixel comes in the cycle after the word is taken; spare wait
    localparam int DRAIN_CYCLES   = 8;

    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          in_valid   = 1'b0;
    logic          in_ready;
    logic [CB-1:0] x_a        = '0;
    logic [CB-1:0] y_a        = '0;
    logic [CB-1:0] x_b        = '0;
    logic [CB-1:0] y_b        = '0;
    logic          out_valid;
    logic          out_ready  = 1'b0;
    logic [CB-1:0] pixel_x;
    logic [CB:0]   pixel_y;
    logic          last_pixel;

    logic          calm       = 1'b0;   // suppress idling on both sides
    int            mismatches;
    int            pixels_pending;
    int            stalled_cycles = 0;

    bresenham_line_points #(
        .COORD_BITS (CB)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_a        (x_a),
        .y_a        (y_a),
        .x_b        (x_b),
        .y_b        (y_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    line_pixel_checker #(
        .COORD_BITS (CB)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .x_a            (x_a),
        .y_a            (y_a),
        .x_b            (x_b),
        .y_b            (y_b),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .last_pixel     (last_pixel),
        .mismatches     (mismatches),
        .pixels_pending (pixels_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Output back-pressure: ready drops about a third of the time.
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Watchdog: too long with neither channel moving a word ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // Present one endpoint word, after an optional random gap, and hold it
    // until the block takes it. Valid is only lowered inside the gap, so it
    // never gets two assignments in one step.
    task automatic send_line(input int xa, ya, xb, yb);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        x_a      <= xa[CB-1:0];
        y_a      <= ya[CB-1:0];
        x_b      <= xb[CB-1:0];
        y_b      <= yb[CB-1:0];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Corner value or anything in range.
    function automatic int edge_coord();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return COORD_MAX;
            default: return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    initial
    begin
        int kind;
        int xa;
        int ya;
        int xb;
        int yb;
        int dx;
        int dy;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed lines ----
        send_line(0, 0, 0, 0);                      // single point at origin
        send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_line(5, 0, 5, COORD_MAX);              // equal x, tall: one pixel
        send_line(0, 0, COORD_MAX, COORD_MAX);      // full diagonal, slope 1
        send_line(0, 0, COORD_MAX, 0);              // full horizontal
        send_line(0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_line(COORD_MAX, COORD_MAX, 0, 0);      // reversed order
        send_line(COORD_MAX, 0, 0, COORD_MAX);      // reversed, falling
        send_line(0, COORD_MAX, COORD_MAX, 0);      // falling y, widest
        send_line(10, 0, 12, COORD_MAX);            // steep: y rises every step
        send_line(0, 0, 1, COORD_MAX);              // steepest two-pixel line
        send_line(0, 0, COORD_MAX, 1);              // shallowest rising line
        send_line(0, COORD_MAX, 1, 0);              // steep and falling
        send_line(0, 0, 1, 0);                      // two pixels, flat
        send_line(1, 0, 0, 1);                      // two pixels, reversed
        send_line(20, 20, 40, 30);                  // exact half slope
        send_line(3, 7, 50, 40);                    // ordinary first octant
        send_line(40, 10, 8, 25);                   // reversed order, falling y
        send_line(0, COORD_MAX, COORD_MAX, COORD_MAX - 1);
        send_line(COORD_MAX - 1, 0, COORD_MAX, COORD_MAX);

        // ---- random lines ----
        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            calm <= (i >= CALM_FIRST && i < CALM_LAST);
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // first-octant line, either endpoint first
                xa = $urandom_range(0, COORD_MAX);
                dx = $urandom_range(0, COORD_MAX - xa);
                dy = $urandom_range(0, dx);
                ya = $urandom_range(0, COORD_MAX - dy);
                xb = xa + dx;
                yb = ya + dy;
                if ($urandom_range(0, 2) == 0)
                    send_line(xb, yb, xa, ya);
                else
                    send_line(xa, ya, xb, yb);
            end
            else if (kind < 75)
                send_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            else if (kind < 90)
            begin
                // short lines (unless xb wraps) keep handshakes dense
                xa = $urandom_range(0, COORD_MAX);
                xb = (xa + $urandom_range(0, 3)) & COORD_MAX;
                send_line(xa, $urandom_range(0, COORD_MAX), xb,
                          $urandom_range(0, COORD_MAX));
            end
            else
                send_line(edge_coord(), edge_coord(), edge_coord(), edge_coord());
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        // let the checker see the last word before trusting its count
        @(posedge clk);
        while (pixels_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pixels_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
